// File: rtl/icl_pkg.sv
// Shared constants, codes and types of the interpolated color lookup.
package icl_pkg;

    localparam int TABLE_DEPTH   = 256;
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 8;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int QUO_W     = IDX_W + FRACTION_BITS;
    localparam int PROD_W    = SAMPLE_BITS + IDX_W;
    localparam int COUNT_W   = 9;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int OUT_DEPTH = 2;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_ZERO = 2'd1;
    localparam logic [1:0] FILL_ONES = 2'd2;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_color;

    typedef struct packed {
        logic                   wr;
        logic                   res;
        logic                   interp;
        logic [1:0]             fill;
        logic [IDX_W-1:0]       base;
        logic [IDX_W-1:0]       wr_index;
        t_color                 wr_color;
        logic [PROD_W-1:0]      product;
        logic [SAMPLE_BITS-1:0] divisor;
    } t_job;

endpackage

// File: rtl/interpolated_color_lookup.sv
// Interpolated color lookup: scalar sample to RGBA through a 256-entry table.
// One item (table write or lookup) is taken per clock while full is low, and
// results come out in order at one per clock unless the result queue is full;
// a lookup passes through the 16-stage divider that forms the
// table position (one quotient bit per stage), followed by a table stage that
// reads both neighbor entries together and a blend stage. Table writes go
// through the same pipeline, so a lookup always sees every write pushed
// before it. Table entries come up undefined after reset and must be written
// before a lookup reaches them. Change the range and count registers only
// while no item is in flight.
module interpolated_color_lookup import icl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_command,
    input  logic [7:0]           i_entry_index,
    input  logic [7:0]           i_entry_red,
    input  logic [7:0]           i_entry_green,
    input  logic [7:0]           i_entry_blue,
    input  logic [7:0]           i_entry_alpha,
    input  logic [15:0]          i_sample,
    input  logic                 i_sample_invalid,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic [7:0]           o_alpha,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]   r_range_lower;
    logic [CFG_W-1:0]   r_range_upper;
    logic [COUNT_W-1:0] r_entry_count;

    logic   job_push;
    t_job   job_in;
    t_job   job_out;
    logic   job_empty;
    logic   job_pop;
    logic   out_full;
    logic   out_push;
    t_color out_color;
    t_color head_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_lower <= '0;
            r_range_upper <= '1;
            r_entry_count <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_RANGE_LOWER: r_range_lower <= i_cfg_data;
                REG_RANGE_UPPER: r_range_upper <= i_cfg_data;
                REG_ENTRY_COUNT: r_entry_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    icl_front u_front (
        .i_push           (push),
        .i_queue_full     (full),
        .i_command        (i_command),
        .i_entry_index    (i_entry_index),
        .i_entry_red      (i_entry_red),
        .i_entry_green    (i_entry_green),
        .i_entry_blue     (i_entry_blue),
        .i_entry_alpha    (i_entry_alpha),
        .i_sample         (i_sample),
        .i_sample_invalid (i_sample_invalid),
        .i_range_lower    (r_range_lower),
        .i_range_upper    (r_range_upper),
        .i_entry_count    (r_entry_count),
        .o_job_push       (job_push),
        .o_job            (job_in)
    );

    icl_job_queue u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_job   (job_out)
    );

    icl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out_color (out_color)
    );

    icl_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_color (out_color),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_color (head_color)
    );

    assign o_red   = head_color.red;
    assign o_green = head_color.green;
    assign o_blue  = head_color.blue;
    assign o_alpha = head_color.alpha;

endmodule

// File: rtl/icl_front.sv
// Front end: accepts items and classifies them into jobs for the back end.
module icl_front import icl_pkg::*; (
    input  logic                   i_push,
    input  logic                   i_queue_full,
    input  logic                   i_command,
    input  logic [7:0]             i_entry_index,
    input  logic [7:0]             i_entry_red,
    input  logic [7:0]             i_entry_green,
    input  logic [7:0]             i_entry_blue,
    input  logic [7:0]             i_entry_alpha,
    input  logic [15:0]            i_sample,
    input  logic                   i_sample_invalid,
    input  logic [CFG_W-1:0]       i_range_lower,
    input  logic [CFG_W-1:0]       i_range_upper,
    input  logic [COUNT_W-1:0]     i_entry_count,
    output logic                   o_job_push,
    output t_job                   o_job
);

    logic [SAMPLE_BITS-1:0] s;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] offset;
    logic [IDX_W-1:0]       last;
    logic                   at_low;
    logic                   at_high;

    assign o_job_push = i_push && !i_queue_full;

    always_comb begin
        s  = SAMPLE_BITS'(i_sample);
        lo = SAMPLE_BITS'(i_range_lower);
        hi = SAMPLE_BITS'(i_range_upper);
        if (32'(i_entry_count) > 32'(TABLE_DEPTH)) begin
            last = IDX_W'(TABLE_DEPTH - 1);
        end else begin
            last = IDX_W'(i_entry_count - 1'b1);
        end
        at_low  = s <= lo;
        at_high = s >= hi;
        offset  = s - lo;

        o_job.wr  = (i_command == CMD_WRITE) && (32'(i_entry_index) < 32'(TABLE_DEPTH));
        o_job.res = i_command == CMD_LOOKUP;
        if (i_sample_invalid) begin
            o_job.fill = FILL_ZERO;
        end else if (i_entry_count == '0) begin
            o_job.fill = FILL_ONES;
        end else begin
            o_job.fill = FILL_NONE;
        end
        o_job.interp         = (o_job.fill == FILL_NONE) && !at_low && !at_high;
        o_job.base           = at_low ? '0 : last;
        o_job.wr_index       = IDX_W'(i_entry_index);
        o_job.wr_color.red   = i_entry_red;
        o_job.wr_color.green = i_entry_green;
        o_job.wr_color.blue  = i_entry_blue;
        o_job.wr_color.alpha = i_entry_alpha;
        o_job.product        = offset * last;
        o_job.divisor        = hi - lo;
    end

endmodule

// File: rtl/icl_job_queue.sv
// Short job queue between the front end and the back end.
module icl_job_queue import icl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job               r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr;
    logic [JOB_PTR_W-1:0] r_rd_ptr;
    logic [JOB_PTR_W:0]   r_count;
    logic [JOB_PTR_W:0]   n_count;

    assign o_full  = r_count == (JOB_PTR_W+1)'(JOB_DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/icl_back.sv
// Back end: pipelined divider, color table and channel blend.
module icl_back import icl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_job   i_job,
    input  logic   i_job_empty,
    output logic   o_job_pop,
    input  logic   i_out_full,
    output logic   o_out_push,
    output t_color o_out_color
);

    typedef struct packed {
        logic                   wr;
        logic                   res;
        logic                   interp;
        logic [1:0]             fill;
        logic [IDX_W-1:0]       base;
        logic [IDX_W-1:0]       wr_index;
        t_color                 wr_color;
        logic [SAMPLE_BITS-1:0] rem;
        logic [QUO_W-1:0]       num;
        logic [QUO_W-1:0]       quo;
        logic [SAMPLE_BITS-1:0] divisor;
    } t_div;

    function automatic t_div div_step(input t_div d);
        t_div                 o;
        logic [SAMPLE_BITS:0] trial;
        o     = d;
        trial = {d.rem, d.num[QUO_W-1]};
        o.num = {d.num[QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, d.divisor}) begin
            o.rem = SAMPLE_BITS'(trial - {1'b0, d.divisor});
            o.quo = {d.quo[QUO_W-2:0], 1'b1};
        end else begin
            o.rem = trial[SAMPLE_BITS-1:0];
            o.quo = {d.quo[QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                       input logic [FRACTION_BITS-1:0] f);
        logic signed [8:0]               d;
        logic signed [FRACTION_BITS+9:0] p;
        logic signed [9:0]               q;
        logic signed [9:0]               sum;
        d   = $signed({1'b0, b}) - $signed({1'b0, a});
        p   = d * $signed({1'b0, f});
        q   = $signed(p[FRACTION_BITS+9:FRACTION_BITS]);
        sum = $signed({2'b00, a}) + q;
        return sum[7:0];
    endfunction

    logic                     en;
    t_div                     load;
    t_div                     r_div [QUO_W+1];
    logic [QUO_W:0]           r_vld;

    logic [IDX_W-1:0]         idx_a;
    logic [IDX_W-1:0]         idx_b;
    logic [FRACTION_BITS-1:0] frac;

    t_color                   r_table [TABLE_DEPTH];
    t_color                   r_rd_a;
    t_color                   r_rd_b;
    logic                     r_m_valid;
    logic [1:0]               r_m_fill;
    logic [FRACTION_BITS-1:0] r_m_frac;

    t_color                   blend;
    logic                     r_out_valid;
    t_color                   r_out_color;

    assign en          = !r_out_valid || !i_out_full;
    assign o_job_pop   = en && !i_job_empty;
    assign o_out_push  = r_out_valid && !i_out_full;
    assign o_out_color = r_out_color;

    always_comb begin
        load.wr       = i_job.wr;
        load.res      = i_job.res;
        load.interp   = i_job.interp;
        load.fill     = i_job.fill;
        load.base     = i_job.base;
        load.wr_index = i_job.wr_index;
        load.wr_color = i_job.wr_color;
        load.rem      = i_job.product[PROD_W-1:IDX_W];
        load.num      = {i_job.product[IDX_W-1:0], FRACTION_BITS'(0)};
        load.quo      = '0;
        load.divisor  = i_job.divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[QUO_W-1:0], !i_job_empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0] <= load;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[k] <= div_step(r_div[k-1]);
            end
        end
    end

    // next entry is held at the last entry in use
    always_comb begin
        if (r_div[QUO_W].interp) begin
            idx_a = r_div[QUO_W].quo[QUO_W-1:FRACTION_BITS];
            idx_b = (idx_a < r_div[QUO_W].base) ? idx_a + 1'b1 : idx_a;
            frac  = r_div[QUO_W].quo[FRACTION_BITS-1:0];
        end else begin
            idx_a = r_div[QUO_W].base;
            idx_b = r_div[QUO_W].base;
            frac  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_vld[QUO_W] && r_div[QUO_W].wr) begin
                r_table[r_div[QUO_W].wr_index] <= r_div[QUO_W].wr_color;
            end
            r_rd_a   <= r_table[idx_a];
            r_rd_b   <= r_table[idx_b];
            r_m_fill <= r_div[QUO_W].fill;
            r_m_frac <= frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_vld[QUO_W] && r_div[QUO_W].res;
        end
    end

    always_comb begin
        case (r_m_fill)
            FILL_ZERO: blend = '0;
            FILL_ONES: blend = '1;
            default: begin
                blend.red   = mix(r_rd_a.red,   r_rd_b.red,   r_m_frac);
                blend.green = mix(r_rd_a.green, r_rd_b.green, r_m_frac);
                blend.blue  = mix(r_rd_a.blue,  r_rd_b.blue,  r_m_frac);
                blend.alpha = mix(r_rd_a.alpha, r_rd_b.alpha, r_m_frac);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_color <= blend;
        end
    end

`ifndef SYNTHESIS
    // an interpolated lookup lands below the last entry unless only one is in use
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[QUO_W] && r_div[QUO_W].res && r_div[QUO_W].interp)
        |-> ((r_div[QUO_W].quo[QUO_W-1:FRACTION_BITS] < r_div[QUO_W].base)
             || (r_div[QUO_W].base == '0)))
        else $error("interpolation index out of range");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !en) |=> (r_out_valid && $stable(r_out_color)))
        else $error("result changed while stalled");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[QUO_W] && !r_div[QUO_W].res) |=> !r_m_valid)
        else $error("table write produced a result");
`endif

endmodule

// File: rtl/icl_out_queue.sv
// Result queue at the output of the back end.
module icl_out_queue import icl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_color i_color,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_color o_color
);

    t_color               r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_PTR_W:0]   r_count;
    logic [OUT_PTR_W:0]   n_count;
    logic                 do_pop;

    assign o_full  = r_count == (OUT_PTR_W+1)'(OUT_DEPTH);
    assign o_empty = r_count == '0;
    assign o_color = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_color;
        end
    end

endmodule
